@@ hdl/xmmp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the measurement message parser: parse phases, result codes
// and the known data identifier table. No dependencies.
package xmmp_pkg;

  // Parse phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_IDHI = 3'd2;
  localparam logic [2:0] PH_IDLO = 3'd3;
  localparam logic [2:0] PH_PLEN = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;

  // Result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  // Quantity codes, Q_NONE marks a packet that is skipped
  localparam logic [2:0] Q_LATLON   = 3'd0;
  localparam logic [2:0] Q_ALTITUDE = 3'd1;
  localparam logic [2:0] Q_VELOCITY = 3'd2;
  localparam logic [2:0] Q_ROT      = 3'd3;
  localparam logic [2:0] Q_EULER    = 3'd4;
  localparam logic [2:0] Q_PRESSURE = 3'd5;
  localparam logic [2:0] Q_ACCEL    = 3'd6;
  localparam logic [2:0] Q_NONE     = 3'd7;

  // Checksum seed
  localparam logic [7:0] SUM_SEED = 8'hFF;

  // Map a data identifier and packet length to a quantity code
  function automatic logic [2:0] lookup_quantity(input logic [15:0] id, input logic [7:0] len);
    logic [2:0] q;
    q = Q_NONE;
    if (id == 16'h5040 && len == 8'h08) q = Q_LATLON;
    if (id == 16'h5020 && len == 8'h04) q = Q_ALTITUDE;
    if (id == 16'hD010 && len == 8'h0C) q = Q_VELOCITY;
    if (id == 16'h8020 && len == 8'h0C) q = Q_ROT;
    if (id == 16'h2030 && len == 8'h0C) q = Q_EULER;
    if (id == 16'h3010 && len == 8'h04) q = Q_PRESSURE;
    if (id == 16'h4020 && len == 8'h0C) q = Q_ACCEL;
    return q;
  endfunction

endpackage

@@ hdl/xbus_measurement_message_parser.sv @@
`timescale 1ns / 1ps
// Top level of the measurement message parser: byte stream in, decoded
// values and end-of-message status out. Depends on xmmp_pkg.

// The parser takes one message byte per cycle, with no gaps needed between
// bytes or messages, and passes each byte through an input register and one
// stage of parse logic into a result register. A value result is produced
// by the last byte of each 32-bit word of a known packet, a status result by
// the checksum byte; all other bytes produce nothing. A status of anything
// but ok means the values of that message should be discarded. Backpressure
// on the result side stalls the input only while the result register holds
// a result that has not been taken.
module xbus_measurement_message_parser (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_message
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] quantity, [4:3] axis_index,
                                      // [36:5] value_bits, [38:37] status, [39] zero
  output logic        m_axis_tuser    // [0] result_kind
);
  import xmmp_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_sop;

  // Parser state
  logic [2:0]  phase;
  logic [7:0]  run_sum;
  logic [7:0]  pay_left;
  logic [15:0] pkt_id;
  logic [7:0]  pkt_left;
  logic [2:0]  pkt_q;
  logic [3:0]  body_idx;
  logic [31:0] word_acc;
  logic        overrun;

  logic [2:0]  phase_next;
  logic [7:0]  run_sum_next;
  logic [7:0]  pay_left_next;
  logic [15:0] pkt_id_next;
  logic [7:0]  pkt_left_next;
  logic [2:0]  pkt_q_next;
  logic [3:0]  body_idx_next;
  logic [31:0] word_acc_next;
  logic        overrun_next;

  // Result register
  logic        out_valid;
  logic        out_kind;
  logic [2:0]  out_quantity;
  logic [1:0]  out_axis;
  logic [31:0] out_value;
  logic [1:0]  out_status;

  logic        emit;
  logic        emit_kind;
  logic [2:0]  emit_quantity;
  logic [1:0]  emit_axis;
  logic [31:0] emit_value;
  logic [1:0]  emit_status;

  logic        advance;
  logic [7:0]  pay_dec;
  logic [7:0]  sum_add;

  // Handshake: parse stage moves when the result register can take a result
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {1'b0, out_status, out_value, out_axis, out_quantity};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_sop  <= s_axis_tuser;
    end
  end

  assign pay_dec = pay_left - 8'd1;
  assign sum_add = run_sum + in_byte;

  // Parse logic for one byte
  always_comb begin
    phase_next    = phase;
    run_sum_next  = run_sum;
    pay_left_next = pay_left;
    pkt_id_next   = pkt_id;
    pkt_left_next = pkt_left;
    pkt_q_next    = pkt_q;
    body_idx_next = body_idx;
    word_acc_next = word_acc;
    overrun_next  = overrun;
    emit          = 1'b0;
    emit_kind     = KIND_VALUE;
    emit_quantity = 3'd0;
    emit_axis     = 2'd0;
    emit_value    = 32'd0;
    emit_status   = ST_OK;

    if (in_sop) begin
      // message id byte: restart from any phase
      phase_next    = PH_LEN;
      run_sum_next  = SUM_SEED + in_byte;
      pay_left_next = 8'd0;
      pkt_id_next   = 16'd0;
      pkt_left_next = 8'd0;
      pkt_q_next    = Q_NONE;
      body_idx_next = 4'd0;
      word_acc_next = 32'd0;
      overrun_next  = 1'b0;
    end else if (phase != PH_IDLE) begin
      run_sum_next = sum_add;
      case (phase)
        PH_LEN: begin
          pay_left_next = in_byte;
          phase_next    = (in_byte == 8'd0) ? PH_CSUM : PH_IDHI;
        end
        PH_CSUM: begin
          emit       = 1'b1;
          emit_kind  = KIND_STATUS;
          if (sum_add != 8'd0) emit_status = ST_CSUM;
          else if (overrun)    emit_status = ST_OVERRUN;
          else                 emit_status = ST_OK;
          phase_next = PH_IDLE;
        end
        default: begin
          // payload byte
          pay_left_next = pay_dec;
          case (phase)
            PH_IDHI: begin
              pkt_id_next = {in_byte, 8'd0};
              phase_next  = PH_IDLO;
            end
            PH_IDLO: begin
              pkt_id_next = {pkt_id[15:8], in_byte};
              phase_next  = PH_PLEN;
            end
            PH_PLEN: begin
              if (in_byte > pay_dec) begin
                overrun_next  = 1'b1;
                pkt_q_next    = Q_NONE;
                pkt_left_next = pay_dec;
              end else begin
                pkt_q_next    = lookup_quantity(pkt_id, in_byte);
                pkt_left_next = in_byte;
              end
              body_idx_next = 4'd0;
              word_acc_next = 32'd0;
              phase_next    = (pkt_left_next == 8'd0) ? PH_IDHI : PH_BODY;
            end
            default: begin
              // packet body: assemble big-endian words
              word_acc_next = {word_acc[23:0], in_byte};
              if (pkt_q != Q_NONE && body_idx[1:0] == 2'd3) begin
                emit          = 1'b1;
                emit_kind     = KIND_VALUE;
                emit_quantity = pkt_q;
                emit_axis     = body_idx[3:2];
                emit_value    = word_acc_next;
              end
              body_idx_next = body_idx + 4'd1;
              pkt_left_next = pkt_left - 8'd1;
              if (pkt_left_next == 8'd0) phase_next = PH_IDHI;
            end
          endcase
          // end of payload: a packet still open means overrun
          if (pay_dec == 8'd0) begin
            if (phase_next != PH_IDHI) overrun_next = 1'b1;
            phase_next = PH_CSUM;
          end
        end
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      run_sum  <= SUM_SEED;
      pay_left <= 8'd0;
      pkt_id   <= 16'd0;
      pkt_left <= 8'd0;
      pkt_q    <= Q_NONE;
      body_idx <= 4'd0;
      word_acc <= 32'd0;
      overrun  <= 1'b0;
    end else if (advance) begin
      phase    <= phase_next;
      run_sum  <= run_sum_next;
      pay_left <= pay_left_next;
      pkt_id   <= pkt_id_next;
      pkt_left <= pkt_left_next;
      pkt_q    <= pkt_q_next;
      body_idx <= body_idx_next;
      word_acc <= word_acc_next;
      overrun  <= overrun_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_kind     <= emit_kind;
      out_quantity <= emit_quantity;
      out_axis     <= emit_axis;
      out_value    <= emit_value;
      out_status   <= emit_status;
    end
  end

  // Assertions
  a_body_open: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> pkt_left != 8'd0)
    else $error("packet body phase with no bytes left");

  a_pkt_in_payload: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> pkt_left <= pay_left)
    else $error("packet extends past payload");

  a_payload_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDHI || phase == PH_IDLO || phase == PH_PLEN || phase == PH_BODY)
      |-> pay_left != 8'd0)
    else $error("payload phase with no payload bytes left");

  a_value_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_VALUE
      |-> out_quantity != Q_NONE && out_axis != 2'd3 && out_status == ST_OK)
    else $error("malformed value result");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS
      |-> out_value == 32'd0 && out_quantity == 3'd0 && out_axis == 2'd0
          && out_status != 2'd3)
    else $error("malformed status result");

endmodule
